FILE: hw/rtl/tlvkv_pkg.sv
package tlvkv_pkg;

  localparam int unsigned STORE_BYTES_DEF     = 1024;
  localparam int unsigned MAX_VALUE_BYTES_DEF = 64;
  localparam int unsigned HDR_BYTES           = 4;
  localparam int unsigned USABLE_RESET        = 1024;
  localparam int unsigned CNT_W               = 11;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EXISTS    = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_NO_SPACE  = 3'd3,
    ST_ERROR     = 3'd4,
    ST_EMPTY     = 3'd5
  } status_t;

  typedef enum logic {
    REQ_ADD    = 1'b0,
    REQ_LOOKUP = 1'b1
  } req_t;

  typedef struct packed {
    status_t          status;
    logic [7:0]       value;
    logic [6:0]       flen;
    logic [CNT_W-1:0] used;
    logic             last;
  } res_t;

endpackage

FILE: hw/rtl/tlv_key_value_store.sv
// An add value byte is written in ADD_BYTE after acceptance; the last one commits in ADD_DONE.
// The first byte of an add is checked in ADD_CHECK, then a duplicate search walks each stored
// record through W_RD0 to W_RD4 and W_CHECK, and the header is written in HDR.
// A lookup passes LK_START, walks each record header through W_RD0 to W_RD4 and W_CHECK, then
// emits a status-only result or streams each value byte; a full output register stalls it.
// Synchronous reset clears the counters and add state, sets usable_size to 1024, keeps the store.
module tlv_key_value_store #(
  parameter int unsigned STORE_BYTES     = tlvkv_pkg::STORE_BYTES_DEF,
  parameter int unsigned MAX_VALUE_BYTES = tlvkv_pkg::MAX_VALUE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // key, value_length, value_byte
  input  logic        s_tuser,   // req_type
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // value_out, found_length, used_bytes, free_bytes
  output logic [2:0]  m_tuser,   // status
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data
);

  import tlvkv_pkg::*;

  localparam int AW = $clog2(STORE_BYTES);

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [7:0]       mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  logic [7:0]       mem_rdata;
  logic             res_valid;
  logic             res_ready;
  res_t             res;
  logic [CNT_W-1:0] eff_usable;

  assign cfg_ready = 1'b1;

  tlvkv_mem #(
    .DEPTH(STORE_BYTES)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  tlvkv_ctrl #(
    .STORE_BYTES    (STORE_BYTES),
    .MAX_VALUE_BYTES(MAX_VALUE_BYTES)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_req_type(req_t'(s_tuser)),
    .in_key     (s_tdata[15:0]),
    .in_vlen    (s_tdata[22:16]),
    .in_vbyte   (s_tdata[30:23]),
    .in_last    (s_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .eff_usable (eff_usable)
  );

  tlvkv_out u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (res_valid),
    .res       (res),
    .eff_usable(eff_usable),
    .space     (res_ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

FILE: hw/rtl/tlvkv_mem.sv
module tlvkv_mem #(
  parameter int unsigned DEPTH = tlvkv_pkg::STORE_BYTES_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [7:0]               wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [7:0]               rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/tlvkv_out.sv
module tlvkv_out (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             load,
  input  tlvkv_pkg::res_t                  res,
  input  logic [tlvkv_pkg::CNT_W-1:0]      eff_usable,
  output logic                             space,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [39:0]                      m_tdata,  // value_out, found_length, used, free
  output logic [2:0]                       m_tuser,  // status
  output logic                             m_tlast
);

  import tlvkv_pkg::*;

  logic [CNT_W-1:0] free_now;

  assign free_now = (res.used > eff_usable) ? '0 : eff_usable - res.used;
  assign space    = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (space) begin
      m_tvalid <= load;
    end
    if (space && load) begin
      m_tdata <= {3'b000, free_now, res.used, res.flen, res.value};
      m_tuser <= res.status;
      m_tlast <= res.last;
    end
  end

endmodule

FILE: hw/rtl/tlvkv_ctrl.sv
module tlvkv_ctrl #(
  parameter int unsigned STORE_BYTES     = tlvkv_pkg::STORE_BYTES_DEF,
  parameter int unsigned MAX_VALUE_BYTES = tlvkv_pkg::MAX_VALUE_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  tlvkv_pkg::req_t                  in_req_type,
  input  logic [15:0]                      in_key,
  input  logic [6:0]                       in_vlen,
  input  logic [7:0]                       in_vbyte,
  input  logic                             in_last,
  input  logic                             cfg_valid,
  input  logic [tlvkv_pkg::CNT_W-1:0]      cfg_data,
  output logic                             mem_we,
  output logic [$clog2(STORE_BYTES)-1:0]   mem_waddr,
  output logic [7:0]                       mem_wdata,
  output logic                             mem_re,
  output logic [$clog2(STORE_BYTES)-1:0]   mem_raddr,
  input  logic [7:0]                       mem_rdata,
  output logic                             res_valid,
  input  logic                             res_ready,
  output tlvkv_pkg::res_t                  res,
  output logic [tlvkv_pkg::CNT_W-1:0]      eff_usable
);

  import tlvkv_pkg::*;

  localparam int AW = $clog2(STORE_BYTES);

  typedef enum logic [3:0] {
    IDLE, ADD_CHECK, HDR, ADD_BYTE, ADD_DONE, LK_START,
    W_RD0, W_RD1, W_RD2, W_RD3, W_RD4, W_CHECK,
    EMIT1, EMIT_RD, EMIT_WT
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] usable_size;
  logic [CNT_W-1:0] used_count;
  logic             add_active;
  status_t          add_verdict;
  logic [6:0]       add_cnt;
  logic [6:0]       add_len;
  logic             walk_add;
  logic [15:0]      r_key;
  logic [6:0]       r_vlen;
  logic [7:0]       r_vbyte;
  logic             r_last;
  logic [CNT_W-1:0] pos;
  logic [7:0]       k_lo, k_hi, l_lo, l_hi;
  logic [1:0]       hc;
  logic [CNT_W-1:0] vaddr;
  logic [6:0]       idx;
  logic [6:0]       flen;
  status_t          res_st;

  logic [15:0]      hdr_len;
  logic [16:0]      rec_end;
  logic             rec_bad;
  logic             key_hit;
  logic             more;
  logic [7:0]       need;
  logic             over;
  logic [CNT_W-1:0] room;
  logic             len_bad;
  logic [CNT_W-1:0] c_need;
  logic [CNT_W-1:0] commit_used;
  status_t          st_done;
  logic             ok_wr;
  logic             emit_last;

  assign eff_usable = (32'(usable_size) > 32'(STORE_BYTES)) ? CNT_W'(STORE_BYTES) : usable_size;

  assign hdr_len = {l_hi, l_lo};
  assign rec_end = 17'(pos) + 17'(HDR_BYTES) + 17'(hdr_len);
  assign rec_bad = (hdr_len == '0) || (hdr_len > 16'(MAX_VALUE_BYTES)) ||
                   (rec_end > 17'(used_count));
  assign key_hit = ({k_hi, k_lo} == r_key);
  assign more    = (rec_end + 17'(HDR_BYTES)) <= 17'(used_count);

  assign need    = 8'(r_vlen) + 8'(HDR_BYTES);
  assign over    = used_count > eff_usable;
  assign room    = eff_usable - used_count;
  assign len_bad = (r_vlen == '0) || (r_vlen > 7'(MAX_VALUE_BYTES)) ||
                   (CNT_W'(need) > eff_usable) || over;

  assign c_need      = CNT_W'(add_len) + CNT_W'(HDR_BYTES);
  assign commit_used = used_count + c_need;
  assign ok_wr       = (add_verdict == ST_OK) && (add_cnt < add_len);
  assign emit_last   = ((idx + 7'd1) == flen);

  always_comb begin
    if (add_verdict != ST_OK) begin
      st_done = add_verdict;
    end else if (add_cnt != add_len) begin
      st_done = ST_ERROR;
    end else if (over || (c_need > room)) begin
      st_done = ST_NO_SPACE;
    end else begin
      st_done = ST_OK;
    end
  end

  assign in_ready = (state == IDLE);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    case (state)
      HDR: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(12'(used_count) + 12'(hc));
        case (hc)
          2'd0:    mem_wdata = r_key[7:0];
          2'd1:    mem_wdata = r_key[15:8];
          2'd2:    mem_wdata = {1'b0, r_vlen};
          default: mem_wdata = 8'd0;
        endcase
      end
      ADD_BYTE: begin
        mem_we    = ok_wr;
        mem_waddr = AW'(12'(used_count) + 12'(HDR_BYTES) + 12'(add_cnt));
        mem_wdata = r_vbyte;
      end
      W_RD0: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(pos);
      end
      W_RD1: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(12'(pos) + 12'd1);
      end
      W_RD2: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(12'(pos) + 12'd2);
      end
      W_RD3: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(12'(pos) + 12'd3);
      end
      EMIT_RD: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(vaddr);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_valid  = 1'b0;
    res.status = ST_OK;
    res.value  = '0;
    res.flen   = '0;
    res.used   = used_count;
    res.last   = 1'b1;
    case (state)
      EMIT1: begin
        res_valid  = 1'b1;
        res.status = res_st;
      end
      EMIT_WT: begin
        res_valid  = 1'b1;
        res.status = ST_EXISTS;
        res.value  = mem_rdata;
        res.flen   = flen;
        res.last   = emit_last;
      end
      ADD_DONE: begin
        res_valid  = 1'b1;
        res.status = st_done;
        res.used   = (st_done == ST_OK) ? commit_used : used_count;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      usable_size <= CNT_W'(USABLE_RESET);
      used_count  <= '0;
      add_active  <= 1'b0;
      add_verdict <= ST_OK;
      add_cnt     <= '0;
    end else begin
      if (cfg_valid) begin
        usable_size <= cfg_data;
      end
      case (state)
        IDLE: begin
          if (in_valid) begin
            r_key   <= in_key;
            r_vlen  <= in_vlen;
            r_vbyte <= in_vbyte;
            r_last  <= in_last;
            if (in_req_type == REQ_LOOKUP) begin
              state <= LK_START;
            end else if (add_active) begin
              state <= ADD_BYTE;
            end else begin
              state <= ADD_CHECK;
            end
          end
        end
        ADD_CHECK: begin
          add_active <= 1'b1;
          add_cnt    <= '0;
          add_len    <= r_vlen;
          walk_add   <= 1'b1;
          pos        <= '0;
          hc         <= '0;
          if (len_bad) begin
            add_verdict <= ST_ERROR;
            state       <= ADD_BYTE;
          end else if (CNT_W'(need) > room) begin
            add_verdict <= ST_NO_SPACE;
            state       <= ADD_BYTE;
          end else if (used_count < CNT_W'(HDR_BYTES)) begin
            add_verdict <= ST_OK;
            state       <= HDR;
          end else begin
            add_verdict <= ST_OK;
            state       <= W_RD0;
          end
        end
        HDR: begin
          hc <= hc + 2'd1;
          if (hc == 2'd3) begin
            state <= ADD_BYTE;
          end
        end
        ADD_BYTE: begin
          if (add_verdict == ST_OK) begin
            if (ok_wr) begin
              add_cnt <= add_cnt + 7'd1;
            end else begin
              add_verdict <= ST_ERROR;
            end
          end
          state <= r_last ? ADD_DONE : IDLE;
        end
        ADD_DONE: begin
          if (res_ready) begin
            if (st_done == ST_OK) begin
              used_count <= commit_used;
            end
            add_active  <= 1'b0;
            add_verdict <= ST_OK;
            add_cnt     <= '0;
            state       <= IDLE;
          end
        end
        LK_START: begin
          walk_add <= 1'b0;
          pos      <= '0;
          if (over) begin
            res_st <= ST_ERROR;
            state  <= EMIT1;
          end else if (used_count < CNT_W'(HDR_BYTES)) begin
            res_st <= ST_EMPTY;
            state  <= EMIT1;
          end else begin
            state <= W_RD0;
          end
        end
        W_RD0: state <= W_RD1;
        W_RD1: begin
          k_lo  <= mem_rdata;
          state <= W_RD2;
        end
        W_RD2: begin
          k_hi  <= mem_rdata;
          state <= W_RD3;
        end
        W_RD3: begin
          l_lo  <= mem_rdata;
          state <= W_RD4;
        end
        W_RD4: begin
          l_hi  <= mem_rdata;
          state <= W_CHECK;
        end
        W_CHECK: begin
          if (rec_bad) begin
            if (walk_add) begin
              add_verdict <= ST_ERROR;
              state       <= ADD_BYTE;
            end else begin
              res_st <= ST_ERROR;
              state  <= EMIT1;
            end
          end else if (key_hit) begin
            if (walk_add) begin
              add_verdict <= ST_EXISTS;
              state       <= ADD_BYTE;
            end else begin
              vaddr <= pos + CNT_W'(HDR_BYTES);
              flen  <= hdr_len[6:0];
              idx   <= '0;
              state <= EMIT_RD;
            end
          end else if (more) begin
            pos   <= rec_end[CNT_W-1:0];
            state <= W_RD0;
          end else if (walk_add) begin
            hc    <= '0;
            state <= HDR;
          end else begin
            res_st <= ST_NOT_FOUND;
            state  <= EMIT1;
          end
        end
        EMIT1: begin
          if (res_ready) begin
            state <= IDLE;
          end
        end
        EMIT_RD: state <= EMIT_WT;
        EMIT_WT: begin
          if (res_ready) begin
            if (emit_last) begin
              state <= IDLE;
            end else begin
              idx   <= idx + 7'd1;
              vaddr <= vaddr + CNT_W'(1);
              state <= EMIT_RD;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
